@@ rtl/qspd_pkg.sv @@
// shared types, character constants and hex helpers for the query string decoder
// no dependencies; used by qspd_decode, qspd_queue and query_string_percent_decoder
package qspd_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_PAIR_END  = 2'd1,
    KIND_ERROR     = 2'd2,
    KIND_QUERY_END = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_INCOMPLETE = 2'd1,
    ERR_INVALID    = 2'd2
  } err_t;

  // escape progress: after '%', after a good first digit, after a bad first digit
  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HI   = 2'd2,
    ESC_BAD  = 2'd3
  } esc_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       value_part;
    err_t       err;
    logic       last;
  } qspd_result_t;

  typedef struct packed {
    logic [1:0]   n;
    qspd_result_t r0;
    qspd_result_t r1;
  } qspd_push_t;

  // bit 4 set when the byte is a hex digit, bits 3:0 its value
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

@@ rtl/query_string_percent_decoder.sv @@
// top level of the query string percent decoder
// depends on qspd_pkg, qspd_decode and qspd_queue
//
//  channel   dir  tdata                                         tuser        tlast
//  s_axis    in   [7:0] in_byte                                 -            in_last
//  m_axis    out  [7:0] out_byte, [8] in_value_part, [10:9] err [1:0] kind   out_last
//  cfg       in   cfg_wdata = plus_to_space, written when cfg_we
//
//  one input byte per cycle; each byte is decoded in the cycle it is taken
//  and its 0, 1 or 2 results land in a small queue, which drains one per cycle while m_axis_tready is high
//  a byte giving two results (only the last byte of a query) pushes both at once;
//  input stalls only while the queue lacks room for two results
//  synchronous active-high reset clears parser state, queue and plus_to_space
module query_string_percent_decoder import qspd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] in_value_part, [10:9] error_code
  output logic [1:0]  m_axis_tuser,   // [1:0] item_kind
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic         plus_to_space;
  logic         accept;
  logic         room;
  qspd_push_t   push;
  qspd_result_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      plus_to_space <= 1'b0;
    end else if (cfg_we) begin
      plus_to_space <= cfg_wdata;
    end
  end

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  qspd_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_byte       (s_axis_tdata),
    .in_last       (s_axis_tlast),
    .plus_to_space (plus_to_space),
    .push          (push)
  );

  qspd_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (m_axis_tready),
    .room      (room),
    .not_empty (m_axis_tvalid),
    .head      (head)
  );

  assign m_axis_tdata = {5'd0, head.err, head.value_part, head.data};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

@@ rtl/qspd_decode.sv @@
// per-byte parser state and classification for the query string decoder
// depends on qspd_pkg; produces up to two results per accepted byte
module qspd_decode import qspd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       plus_to_space,
  output qspd_push_t push
);

  logic       first_pending, first_pending_next;
  logic       value_phase, value_phase_next;
  esc_t       esc, esc_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       pair_has, pair_has_next;
  logic       err_latched, err_latched_next;

  qspd_result_t res [2];
  logic [1:0]   cnt;
  logic         delim;
  logic [4:0]   hx;

  always_comb begin
    first_pending_next = first_pending;
    value_phase_next   = value_phase;
    esc_next           = esc;
    high_nibble_next   = high_nibble;
    pair_has_next      = pair_has;
    err_latched_next   = err_latched;
    res[0]   = '0;
    res[1]   = '0;
    cnt      = 2'd0;
    delim    = (in_byte == CH_AMP) || (in_byte == CH_EQ && !value_phase);
    hx       = hex_digit(in_byte);

    if (err_latched) begin
      if (in_last) begin
        res[0].kind = KIND_QUERY_END;
        cnt         = 2'd1;
      end
    end else begin
      first_pending_next = 1'b0;
      if (!(first_pending && in_byte == CH_QM)) begin
        if (esc != ESC_NONE) begin
          if (delim) begin
            res[0].kind      = KIND_ERROR;
            res[0].err       = ERR_INCOMPLETE;
            cnt              = 2'd1;
            err_latched_next = 1'b1;
          end else begin
            case (esc)
              ESC_PCT: begin
                if (hx[4]) begin
                  high_nibble_next = hx[3:0];
                  esc_next         = ESC_HI;
                end else begin
                  esc_next = ESC_BAD;
                end
              end
              ESC_HI: begin
                if (hx[4]) begin
                  res[0].kind       = KIND_BYTE;
                  res[0].data       = {high_nibble, hx[3:0]};
                  res[0].value_part = value_phase;
                  esc_next          = ESC_NONE;
                end else begin
                  res[0].kind      = KIND_ERROR;
                  res[0].err       = ERR_INVALID;
                  err_latched_next = 1'b1;
                end
                cnt = 2'd1;
              end
              default: begin
                res[0].kind      = KIND_ERROR;
                res[0].err       = ERR_INVALID;
                cnt              = 2'd1;
                err_latched_next = 1'b1;
              end
            endcase
          end
        end else if (in_byte == CH_AMP) begin
          if (pair_has) begin
            res[0].kind = KIND_PAIR_END;
            cnt         = 2'd1;
          end
          pair_has_next    = 1'b0;
          value_phase_next = 1'b0;
        end else if (in_byte == CH_EQ && !value_phase) begin
          value_phase_next = 1'b1;
          pair_has_next    = 1'b1;
        end else if (in_byte == CH_PCT) begin
          esc_next      = ESC_PCT;
          pair_has_next = 1'b1;
        end else begin
          res[0].kind       = KIND_BYTE;
          res[0].data       = (in_byte == CH_PLUS && plus_to_space) ? CH_SPACE : in_byte;
          res[0].value_part = value_phase;
          cnt               = 2'd1;
          pair_has_next     = 1'b1;
        end
      end

      if (in_last) begin
        // close the query: open escape or open pair, else a bare query end if the byte gave no result
        if (!err_latched_next && esc_next != ESC_NONE) begin
          res[cnt[0]].kind = KIND_ERROR;
          res[cnt[0]].err  = ERR_INCOMPLETE;
          cnt              = cnt + 2'd1;
        end else if (!err_latched_next && pair_has_next) begin
          res[cnt[0]].kind = KIND_PAIR_END;
          cnt              = cnt + 2'd1;
        end else if (cnt == 2'd0) begin
          res[0].kind = KIND_QUERY_END;
          cnt         = 2'd1;
        end
      end
    end

    if (in_last) begin
      if (cnt == 2'd2) begin
        res[1].last = 1'b1;
      end else begin
        res[0].last = 1'b1;
      end
      first_pending_next = 1'b1;
      value_phase_next   = 1'b0;
      esc_next           = ESC_NONE;
      high_nibble_next   = 4'd0;
      pair_has_next      = 1'b0;
      err_latched_next   = 1'b0;
    end
  end

  always_comb begin
    push.n  = accept ? cnt : 2'd0;
    push.r0 = res[0];
    push.r1 = res[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending <= 1'b1;
      value_phase   <= 1'b0;
      esc           <= ESC_NONE;
      high_nibble   <= 4'd0;
      pair_has      <= 1'b0;
      err_latched   <= 1'b0;
    end else if (accept) begin
      first_pending <= first_pending_next;
      value_phase   <= value_phase_next;
      esc           <= esc_next;
      high_nibble   <= high_nibble_next;
      pair_has      <= pair_has_next;
      err_latched   <= err_latched_next;
    end
  end

  // a latched error lets only the query end through
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    (err_latched && push.n != 2'd0) |-> (push.r0.kind == KIND_QUERY_END && push.r0.last))
    else $error("result other than query end while error latched");

  // two results only on the final byte, and the second one carries last
  a_two_on_last: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> (in_last && push.r1.last && !push.r0.last))
    else $error("two results without closing the query");

  // the final byte returns the parser to its start state
  a_query_reset: assert property (@(posedge clk) disable iff (rst)
    (accept && in_last) |=> (first_pending && !err_latched && esc == ESC_NONE && !pair_has))
    else $error("parser state not cleared after query end");

endmodule

@@ rtl/qspd_queue.sv @@
// small result queue: takes up to two results a cycle, hands out one while pop is high
// depends on qspd_pkg; head entry drives the output channel directly
module qspd_queue import qspd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  qspd_push_t   push,
  input  logic         pop,
  output logic         room,
  output logic         not_empty,
  output qspd_result_t head
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  qspd_result_t  q [DEPTH];
  qspd_result_t  q_next [DEPTH];
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] count_v;
  logic [IW-1:0] idx0, idx1;

  always_comb begin
    q_next  = q;
    count_v = count;
    if (pop && count != '0) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        q_next[i] = q[i + 1];
      end
      count_v = count - CW'(1);
    end
    idx0 = count_v[IW-1:0];
    idx1 = count_v[IW-1:0] + IW'(1);
    if (push.n != 2'd0) begin
      q_next[idx0] = push.r0;
    end
    if (push.n == 2'd2) begin
      q_next[idx1] = push.r1;
    end
    count_next = count_v + CW'(push.n);
  end

  always_ff @(posedge clk) begin
    q <= q_next;
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // room for the two results the next byte may produce
  assign room      = (count <= CW'(DEPTH - 2));
  assign not_empty = (count != '0);
  assign head      = q[0];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue overflow");

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> (count <= CW'(DEPTH - 2)))
    else $error("double push without room");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && not_empty && push.n == 2'd0) |=> (count == $past(count) - CW'(1)))
    else $error("count wrong after plain pop");

endmodule

@@ verif/tb_query_string_percent_decoder.sv @@
`timescale 1ns / 100ps
// self-checking testbench for query_string_percent_decoder: byte streams in, decoded items out
// needs qspd_pkg and the decoder rtl; the expected items come from a behavioral tracker below
module tb_query_string_percent_decoder;
  import qspd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 80;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PHASE_ITEMS    = 380;

  // tracks the decoder state and holds the items it must produce, oldest first
  class query_result_board;
    bit           plus_to_space;
    bit           first_byte_pending;
    bit           value_phase;
    esc_t         escape_state;
    logic [3:0]   high_nibble;
    bit           pair_has_bytes;
    bit           error_latched;
    qspd_result_t pending_results[$];
    qspd_result_t step_results[$];
    int           bytes_taken;
    int           bytes_decoded;
    int           results_checked;
    int           mismatches;
    int           kind_count[4];

    function new();
      plus_to_space = 1'b0;
      clear_query();
    endfunction

    function void clear_query();
      first_byte_pending = 1'b1;
      value_phase        = 1'b0;
      escape_state       = ESC_NONE;
      high_nibble        = 4'h0;
      pair_has_bytes     = 1'b0;
      error_latched      = 1'b0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function int hex_value(logic [7:0] b);
      int v;
      v = -1;
      if (b >= 8'h30 && b <= 8'h39) v = int'(b) - 32'h30;
      else if (b >= 8'h61 && b <= 8'h66) v = int'(b) - 32'h61 + 10;
      else if (b >= 8'h41 && b <= 8'h46) v = int'(b) - 32'h41 + 10;
      return v;
    endfunction

    function void emit(kind_t kind, logic [7:0] data, logic vp, err_t err);
      qspd_result_t r;
      r.kind       = kind;
      r.data       = data;
      r.value_part = vp;
      r.err        = err;
      r.last       = 1'b0;
      step_results.insert(step_results.size(), r);
    endfunction

    // one accepted input byte: update the parse state and queue what it yields
    function void take_byte(logic [7:0] b, logic last);
      bit           first;
      bit           delim;
      int           h;
      qspd_result_t r;
      step_results.delete();
      bytes_taken++;
      first = first_byte_pending;
      if (error_latched) begin
        if (last) begin
          emit(KIND_QUERY_END, 8'h00, 1'b0, ERR_NONE);
          clear_query();
        end
      end else begin
        bytes_decoded++;
        first_byte_pending = 1'b0;
        if (!(first && b == CH_QM)) begin
          delim = (b == CH_AMP) || (b == CH_EQ && !value_phase);
          if (escape_state != ESC_NONE) begin
            h = hex_value(b);
            if (delim) begin
              emit(KIND_ERROR, 8'h00, 1'b0, ERR_INCOMPLETE);
              error_latched = 1'b1;
            end else if (escape_state == ESC_PCT) begin
              if (h < 0) begin
                escape_state = ESC_BAD;
              end else begin
                high_nibble  = 4'(h);
                escape_state = ESC_HI;
              end
            end else if (escape_state == ESC_HI && h >= 0) begin
              emit(KIND_BYTE, {high_nibble, 4'(h)}, value_phase, ERR_NONE);
              escape_state = ESC_NONE;
            end else begin
              emit(KIND_ERROR, 8'h00, 1'b0, ERR_INVALID);
              error_latched = 1'b1;
            end
          end else if (b == CH_AMP) begin
            if (pair_has_bytes) emit(KIND_PAIR_END, 8'h00, 1'b0, ERR_NONE);
            pair_has_bytes = 1'b0;
            value_phase    = 1'b0;
          end else if (b == CH_EQ && !value_phase) begin
            value_phase    = 1'b1;
            pair_has_bytes = 1'b1;
          end else if (b == CH_PCT) begin
            escape_state   = ESC_PCT;
            pair_has_bytes = 1'b1;
          end else begin
            emit(KIND_BYTE, (b == CH_PLUS && plus_to_space) ? CH_SPACE : b,
                 value_phase, ERR_NONE);
            pair_has_bytes = 1'b1;
          end
        end
        if (last) begin
          if (!error_latched) begin
            if (escape_state != ESC_NONE) emit(KIND_ERROR, 8'h00, 1'b0, ERR_INCOMPLETE);
            else if (pair_has_bytes) emit(KIND_PAIR_END, 8'h00, 1'b0, ERR_NONE);
          end
          if (step_results.size() == 0) emit(KIND_QUERY_END, 8'h00, 1'b0, ERR_NONE);
          clear_query();
        end
      end
      if (last) begin
        r      = step_results[step_results.size() - 1];
        r.last = 1'b1;
        step_results[step_results.size() - 1] = r;
      end
      foreach (step_results[i]) pending_results.insert(pending_results.size(), step_results[i]);
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic [1:0] kind, logic [7:0] data, logic vp, logic [1:0] err,
                      logic last);
      qspd_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected item kind %0d byte %02h", kind, data));
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      kind_count[want.kind]++;
      if (kind !== want.kind)
        report($sformatf("item_kind %0d, want %0d", kind, want.kind));
      if (data !== want.data)
        report($sformatf("out_byte %02h, want %02h", data, want.data));
      if (vp !== want.value_part)
        report($sformatf("in_value_part %0b, want %0b", vp, want.value_part));
      if (err !== want.err)
        report($sformatf("error_code %0d, want %0d", err, want.err));
      if (last !== want.last)
        report($sformatf("out_last %0b, want %0b", last, want.last));
    endtask
  endclass

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] in_byte
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] out_byte, [8] in_value_part, [10:9] error_code
  logic [1:0]  m_axis_tuser;           // [1:0] item_kind
  logic        m_axis_tlast;
  logic        cfg_we        = 1'b0;
  logic        cfg_wdata     = 1'b0;

  query_result_board board = new();
  logic [7:0]        query_bytes[$];
  bit                src_idle_on;
  bit                sink_idle_on;
  bit                long_hold_req;
  bit                plus_seen[2];

  query_string_percent_decoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) board.take_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        board.check_result(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8],
                           m_axis_tdata[10:9], m_axis_tlast);
    end
  end

  // output side: random stall bursts, plus one long hold on request
  initial begin : sink
    int burst;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (sink_idle_on && $urandom_range(0, 99) < 12) begin
        burst = $urandom_range(1, 19);
        m_axis_tready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transaction for %0d cycles, %0d items still owed",
             WATCHDOG_LIMIT, board.pending());
    $display("tb_query_string_percent_decoder: done, errors");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (src_idle_on && $urandom_range(0, 99) < 12) begin
      gap = $urandom_range(1, 19);
      @(negedge clk) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_query();
    foreach (query_bytes[i]) send_byte(query_bytes[i], i == query_bytes.size() - 1);
    query_bytes.delete();
  endtask

  // stop offering and wait for every owed item
  task automatic drain_outputs();
    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic write_plus_to_space(input bit v);
    drain_outputs();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we              <= 1'b1;
    cfg_wdata           <= v;
    board.plus_to_space  = v;
    plus_seen[v]         = 1'b1;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) query_bytes.insert(query_bytes.size(), s[i]);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 10) c = 8'h30 + n;
    else c = ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10;
    return c;
  endfunction

  function automatic logic [7:0] plain_char(input bit in_value);
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 10) c = CH_PLUS;
    else if (r < 15 && in_value) c = CH_EQ;
    else if (r < 17) c = CH_QM;
    else if (r < 60) c = 8'h61 + 8'($urandom_range(0, 25));
    else if (r < 75) c = 8'h30 + 8'($urandom_range(0, 9));
    else begin
      // any other byte that is not a delimiter or an escape start
      do c = 8'($urandom_range(0, 255)); while (c == CH_PCT || c == CH_AMP || c == CH_EQ);
    end
    return c;
  endfunction

  function automatic void add_token(input bit in_value);
    logic [7:0] v;
    if ($urandom_range(0, 99) < 25) begin
      v = 8'($urandom_range(0, 255));
      query_bytes.insert(query_bytes.size(), CH_PCT);
      query_bytes.insert(query_bytes.size(), hex_char(v[7:4]));
      query_bytes.insert(query_bytes.size(), hex_char(v[3:0]));
    end else begin
      query_bytes.insert(query_bytes.size(), plain_char(in_value));
    end
  endfunction

  function automatic void build_well_formed();
    int npairs;
    if ($urandom_range(0, 1)) query_bytes.insert(query_bytes.size(), CH_QM);
    npairs = $urandom_range(1, 4);
    for (int p = 0; p < npairs; p++) begin
      if (p > 0) query_bytes.insert(query_bytes.size(), CH_AMP);
      if ($urandom_range(0, 99) >= 10) begin
        repeat ($urandom_range(0, 4)) add_token(1'b0);
        if ($urandom_range(0, 99) < 85) begin
          query_bytes.insert(query_bytes.size(), CH_EQ);
          repeat ($urandom_range(0, 5)) add_token(1'b1);
        end
      end
    end
    if ($urandom_range(0, 99) < 10) query_bytes.insert(query_bytes.size(), CH_AMP);
    if (query_bytes.size() == 0) query_bytes.insert(query_bytes.size(), CH_AMP);
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: c = CH_PCT;
      1: c = CH_AMP;
      2: c = CH_EQ;
      3: c = CH_QM;
      4: c = CH_PLUS;
      5: c = hex_char(4'($urandom_range(0, 15)));
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  function automatic void build_query();
    int r;
    int pos;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      build_well_formed();
    end else if (r < 85) begin
      // well-formed query plus one escape: broken if cut short, or if its two noise bytes are not both hex
      build_well_formed();
      case ($urandom_range(0, 3))
        0: query_bytes.insert(query_bytes.size(), CH_PCT);
        1: begin
          query_bytes.insert(query_bytes.size(), CH_PCT);
          query_bytes.insert(query_bytes.size(), hex_char(4'($urandom_range(0, 15))));
        end
        2: begin
          pos = $urandom_range(0, query_bytes.size());
          query_bytes.insert(pos, noise_byte());
          query_bytes.insert(pos, noise_byte());
          query_bytes.insert(pos, CH_PCT);
        end
        default: begin
          pos = $urandom_range(0, query_bytes.size());
          query_bytes.insert(pos, $urandom_range(0, 1) ? CH_AMP : CH_EQ);
          if ($urandom_range(0, 1))
            query_bytes.insert(pos, hex_char(4'($urandom_range(0, 15))));
          query_bytes.insert(pos, CH_PCT);
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 10)) query_bytes.insert(query_bytes.size(), noise_byte());
    end
  endfunction

  // idle_mode: 0 none, 1 both sides, 2 switched per query
  task automatic run_phase(input int n_items, input int idle_mode, input bit with_hold,
                           input bit with_pause);
    int start;
    bit paused;
    start  = board.bytes_taken;
    paused = 1'b0;
    src_idle_on  = (idle_mode != 0);
    sink_idle_on = (idle_mode != 0);
    if (with_hold) long_hold_req = 1'b1;
    while (board.bytes_taken - start < n_items) begin
      if (idle_mode == 2) begin
        src_idle_on  = 1'($urandom_range(0, 1));
        sink_idle_on = 1'($urandom_range(0, 1));
      end
      build_query();
      send_query();
      if (with_pause && !paused && board.bytes_taken - start > n_items / 2) begin
        drain_outputs();
        paused = 1'b1;
      end else if (idle_mode != 0 && $urandom_range(0, 99) < 3) begin
        drain_outputs();
      end
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    write_plus_to_space(1'b0);

    push_text("?k=v=%4a&&");
    send_query();
    push_text("?");
    send_query();
    push_text("=");
    send_query();
    push_text("%F");
    send_query();
    push_text("%A=x");
    send_query();
    push_text("%G1");
    send_query();
    push_text("+");
    send_query();
    query_bytes.insert(query_bytes.size(), 8'h00);
    query_bytes.insert(query_bytes.size(), 8'hFF);
    send_query();

    write_plus_to_space(1'b1);
    push_text("+");
    send_query();
    run_phase(PHASE_ITEMS, 1, 1'b0, 1'b1);
    write_plus_to_space(1'b0);
    run_phase(PHASE_ITEMS, 1, 1'b1, 1'b0);
    write_plus_to_space(1'b1);
    run_phase(PHASE_ITEMS, 2, 1'b0, 1'b0);
    write_plus_to_space(1'b0);
    run_phase(PHASE_ITEMS, 0, 1'b0, 1'b0);

    drain_outputs();
    repeat (10) @(posedge clk);
    $display("coverage: %0d bytes taken (%0d parsed), %0d items checked",
             board.bytes_taken, board.bytes_decoded, board.results_checked);
    $display("coverage: %0d data, %0d pair ends, %0d errors, %0d query ends; plus_to_space %0d/%0d",
             board.kind_count[KIND_BYTE], board.kind_count[KIND_PAIR_END],
             board.kind_count[KIND_ERROR], board.kind_count[KIND_QUERY_END],
             plus_seen[0], plus_seen[1]);
    if (board.mismatches == 0) begin
      $display("tb_query_string_percent_decoder: done, clean");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("tb_query_string_percent_decoder: done, errors");
    end
    $finish;
  end

endmodule
